// ===== hdl/assert_macros.svh =====
// assertion macros shared by the sequencer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside reset
`define ACS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked on every rising edge, reset included
`define ACS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hdl/acs_pkg.sv =====
// constants shared by the conversion sequencer
`default_nettype none

package acs_pkg;

  localparam int unsigned HalfPeriodWidth = 16;
  localparam int unsigned WaitLimitWidth  = 12;
  localparam int unsigned ChannelWidth    = 3;
  localparam int unsigned DataWidth       = 8;
  localparam int unsigned CfgDataWidth    = 16;
  localparam int unsigned CfgIndexWidth   = 1;

  localparam logic [HalfPeriodWidth-1:0] HalfPeriodReset = 16'd100;
  localparam logic [WaitLimitWidth-1:0]  WaitLimitReset  = 12'd2000;

  localparam logic [CfgIndexWidth-1:0] RegHalfPeriod = 1'b0;
  localparam logic [CfgIndexWidth-1:0] RegWaitLimit  = 1'b1;

endpackage

`default_nettype wire

// ===== hdl/adc_conversion_sequencer_core.sv =====
// Conversion sequencer for an eight-channel successive-approximation converter:
// every request on the input channel is one system clock tick carrying the
// sampled end-of-conversion level and data byte; the sequencer state advances
// once per accepted request and one result (the pin drive levels and status
// after that tick) leaves through a single output register.
// A request can be accepted every cycle; input stall follows the output stall
// only while the output register holds an untaken result. The cycle path is the
// segment counter compare plus the phase update. Registers half_period_cycles
// and wait_limit may be written at any time and take effect on the next tick.
`default_nettype none
`include "assert_macros.svh"

module adc_conversion_sequencer_core
  import acs_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst_n,

  input  wire logic                       cfg_we,
  input  wire logic [CfgIndexWidth-1:0]   cfg_index,
  input  wire logic [CfgDataWidth-1:0]    cfg_data,

  input  wire logic                       in_valid,
  output      logic                       in_stall,
  input  wire logic                       in_request,
  input  wire logic [ChannelWidth-1:0]    in_channel,
  input  wire logic                       in_eoc_pin,
  input  wire logic [DataWidth-1:0]       in_data_pins,

  output      logic                       out_valid,
  input  wire logic                       out_stall,
  output      logic [ChannelWidth-1:0]    out_address_pins,
  output      logic                       out_latch_pin,
  output      logic                       out_start_pin,
  output      logic                       out_enable_pin,
  output      logic                       out_conv_clock_pin,
  output      logic                       out_busy_res,
  output      logic                       out_sample_valid,
  output      logic [DataWidth-1:0]       out_sample,
  output      logic                       out_wait_timed_out
);

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_SETUP     = 4'd1,
    PH_LATCH     = 4'd2,
    PH_START_HI  = 4'd3,
    PH_START_CLK = 4'd4,
    PH_WAIT_LOW  = 4'd5,
    PH_WAIT_HIGH = 4'd6,
    PH_OUT1      = 4'd7,
    PH_OUT2      = 4'd8,
    PH_OUT3      = 4'd9,
    PH_OUT4      = 4'd10,
    PH_CLOSE     = 4'd11
  } phase_t;

  logic [HalfPeriodWidth-1:0] half_period_cycles_r;
  logic [WaitLimitWidth-1:0]  wait_limit_r;

  phase_t                     phase_r, phase_nxt;
  logic [HalfPeriodWidth-1:0] half_period_count_r, half_period_count_nxt;
  logic [WaitLimitWidth-1:0]  edge_wait_count_r, edge_wait_count_nxt;
  logic [ChannelWidth-1:0]    held_channel_r, held_channel_nxt;
  logic                       clock_level_r, clock_level_nxt;
  logic [DataWidth-1:0]       held_sample_r, held_sample_nxt;
  logic                       timeout_seen_r, timeout_seen_nxt;
  logic                       done_nxt;

  logic                       out_valid_r;
  logic [ChannelWidth-1:0]    out_address_pins_r;
  logic                       out_latch_pin_r;
  logic                       out_start_pin_r;
  logic                       out_enable_pin_r;
  logic                       out_conv_clock_pin_r;
  logic                       out_busy_res_r;
  logic                       out_sample_valid_r;
  logic [DataWidth-1:0]       out_sample_r;
  logic                       out_wait_timed_out_r;

  logic                       in_accept;
  logic [HalfPeriodWidth:0]   hp_inc;
  logic                       seg_end;
  logic [WaitLimitWidth:0]    ew_inc;
  logic                       edge_seen;
  logic                       wait_over;

  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;

  assign hp_inc    = {1'b0, half_period_count_r} + {{HalfPeriodWidth{1'b0}}, 1'b1};
  assign seg_end   = hp_inc >= {1'b0, half_period_cycles_r};
  assign ew_inc    = {1'b0, edge_wait_count_r} + {{WaitLimitWidth{1'b0}}, 1'b1};
  assign edge_seen = (phase_r == PH_WAIT_LOW) ? !in_eoc_pin : in_eoc_pin;
  assign wait_over = ew_inc >= {1'b0, wait_limit_r};

  always_comb begin
    phase_nxt             = phase_r;
    half_period_count_nxt = half_period_count_r;
    edge_wait_count_nxt   = edge_wait_count_r;
    held_channel_nxt      = held_channel_r;
    clock_level_nxt       = clock_level_r;
    held_sample_nxt       = held_sample_r;
    timeout_seen_nxt      = timeout_seen_r;
    done_nxt              = 1'b0;

    if (phase_r == PH_IDLE || phase_r > PH_CLOSE) begin
      phase_nxt       = PH_IDLE;
      clock_level_nxt = 1'b0;
      if (in_request) begin
        held_channel_nxt      = in_channel;
        timeout_seen_nxt      = 1'b0;
        edge_wait_count_nxt   = '0;
        phase_nxt             = PH_SETUP;
        half_period_count_nxt = '0;
      end
    end else if (!seg_end) begin
      half_period_count_nxt = hp_inc[HalfPeriodWidth-1:0];
    end else begin
      half_period_count_nxt = '0;
      unique case (phase_r)
        PH_SETUP: begin
          phase_nxt       = PH_LATCH;
          clock_level_nxt = 1'b1;
        end
        PH_LATCH: begin
          phase_nxt       = PH_START_HI;
          clock_level_nxt = 1'b0;
        end
        PH_START_HI: begin
          phase_nxt       = PH_START_CLK;
          clock_level_nxt = 1'b1;
        end
        PH_START_CLK: begin
          edge_wait_count_nxt = '0;
          phase_nxt           = PH_WAIT_LOW;
          clock_level_nxt     = 1'b1;
        end
        PH_WAIT_LOW, PH_WAIT_HIGH: begin
          if (edge_seen || wait_over) begin
            if (!edge_seen) begin
              timeout_seen_nxt = 1'b1;
            end
            edge_wait_count_nxt = '0;
            if (phase_r == PH_WAIT_LOW) begin
              phase_nxt       = PH_WAIT_HIGH;
              clock_level_nxt = !clock_level_r;
            end else begin
              phase_nxt       = PH_OUT1;
              clock_level_nxt = 1'b0;
            end
          end else begin
            edge_wait_count_nxt = ew_inc[WaitLimitWidth-1:0];
            clock_level_nxt     = !clock_level_r;
          end
        end
        PH_OUT1: begin
          phase_nxt       = PH_OUT2;
          clock_level_nxt = 1'b1;
        end
        PH_OUT2: begin
          phase_nxt       = PH_OUT3;
          clock_level_nxt = 1'b0;
        end
        PH_OUT3: begin
          held_sample_nxt = in_data_pins;
          phase_nxt       = PH_OUT4;
          clock_level_nxt = 1'b1;
        end
        PH_OUT4: begin
          phase_nxt       = PH_CLOSE;
          clock_level_nxt = 1'b0;
        end
        default: begin
          // closing half period
          phase_nxt       = PH_IDLE;
          clock_level_nxt = 1'b0;
          done_nxt        = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_cycles_r <= HalfPeriodReset;
      wait_limit_r         <= WaitLimitReset;
      phase_r              <= PH_IDLE;
      half_period_count_r  <= '0;
      edge_wait_count_r    <= '0;
      held_channel_r       <= '0;
      clock_level_r        <= 1'b0;
      held_sample_r        <= '0;
      timeout_seen_r       <= 1'b0;
      out_valid_r          <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          RegHalfPeriod: half_period_cycles_r <= cfg_data[HalfPeriodWidth-1:0];
          RegWaitLimit:  wait_limit_r         <= cfg_data[WaitLimitWidth-1:0];
          default: ;
        endcase
      end
      if (in_accept) begin
        phase_r             <= phase_nxt;
        half_period_count_r <= half_period_count_nxt;
        edge_wait_count_r   <= edge_wait_count_nxt;
        held_channel_r      <= held_channel_nxt;
        clock_level_r       <= clock_level_nxt;
        held_sample_r       <= held_sample_nxt;
        timeout_seen_r      <= timeout_seen_nxt;
        out_valid_r         <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result register, payload only
  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_address_pins_r   <= held_channel_nxt;
      out_latch_pin_r      <= (phase_nxt == PH_LATCH) || (phase_nxt == PH_START_HI);
      out_start_pin_r      <= (phase_nxt == PH_START_HI) || (phase_nxt == PH_START_CLK);
      out_enable_pin_r     <= (phase_nxt >= PH_OUT1) && (phase_nxt <= PH_OUT4);
      out_conv_clock_pin_r <= clock_level_nxt;
      out_busy_res_r       <= phase_nxt != PH_IDLE;
      out_sample_valid_r   <= done_nxt;
      out_sample_r         <= held_sample_nxt;
      out_wait_timed_out_r <= timeout_seen_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_address_pins   = out_address_pins_r;
  assign out_latch_pin      = out_latch_pin_r;
  assign out_start_pin      = out_start_pin_r;
  assign out_enable_pin     = out_enable_pin_r;
  assign out_conv_clock_pin = out_conv_clock_pin_r;
  assign out_busy_res       = out_busy_res_r;
  assign out_sample_valid   = out_sample_valid_r;
  assign out_sample         = out_sample_r;
  assign out_wait_timed_out = out_wait_timed_out_r;

  `ACS_ASSERT(a_accept_fills_out, in_accept |=> out_valid_r, "accepted request left no result")
  `ACS_ASSERT(a_done_means_idle, (out_valid_r && out_sample_valid_r) |-> !out_busy_res_r, "sample_valid while busy")
  `ACS_ASSERT(a_idle_clock_low, (phase_r == PH_IDLE) |-> !clock_level_r, "converter clock high while idle")
  `ACS_ASSERT(a_latch_enable_excl, out_valid_r |-> !(out_latch_pin_r && out_enable_pin_r), "latch and output enable together")

endmodule

`default_nettype wire
